### design/slpe_pkg.sv
`timescale 1ns / 1ps
// slpe_pkg: shared types, codes and constants of the status LED pattern engine.
// No dependencies; used by every module in the design folder.
package slpe_pkg;

    localparam int OP_W       = 2;
    localparam int PATTERN_W  = 3;
    localparam int COLOR_W    = 24;
    localparam int DURATION_W = 16;
    localparam int LEVEL_W    = 8;
    localparam int INTERVAL_W = 10;
    localparam int CFG_IDX_W  = 1;

    typedef enum logic [OP_W-1:0] {
        OP_TICK  = 2'd0,
        OP_SET   = 2'd1,
        OP_FLASH = 2'd2
    } op_t;

    typedef enum logic [PATTERN_W-1:0] {
        PAT_OFF          = 3'd0,
        PAT_GREEN        = 3'd1,
        PAT_BLUE         = 3'd2,
        PAT_PURPLE       = 3'd3,
        PAT_BREATH_RED   = 3'd4,
        PAT_BREATH_YELLOW = 3'd5,
        PAT_BLINK_WHITE  = 3'd6
    } pattern_t;

    localparam logic [CFG_IDX_W-1:0] CFG_BREATH_INTERVAL = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLINK_INTERVAL  = 1'b1;

    localparam logic [INTERVAL_W-1:0] BREATH_INTERVAL_RST = 10'd20;
    localparam logic [INTERVAL_W-1:0] BLINK_INTERVAL_RST  = 10'd500;
    localparam logic [INTERVAL_W-1:0] ELAPSED_MAX         = 10'd1023;

    localparam logic [LEVEL_W-1:0] BREATH_STEP  = 8'd5;
    localparam logic [LEVEL_W-1:0] BREATH_TOP   = 8'd255;
    localparam logic [LEVEL_W-1:0] BREATH_FLOOR = 8'd10;

    localparam logic [COLOR_W-1:0] COLOR_DARK   = 24'h000000;
    localparam logic [COLOR_W-1:0] COLOR_GREEN  = 24'h00FF00;
    localparam logic [COLOR_W-1:0] COLOR_BLUE   = 24'h0000FF;
    localparam logic [COLOR_W-1:0] COLOR_PURPLE = 24'h8000FF;
    localparam logic [COLOR_W-1:0] COLOR_WHITE  = 24'hFFFFFF;

    typedef struct packed {
        logic [OP_W-1:0]       op;
        logic [PATTERN_W-1:0]  pattern;
        logic [COLOR_W-1:0]    flash_color;
        logic [DURATION_W-1:0] flash_duration;
    } item_t;

endpackage

### design/status_led_pattern_engine.sv
`timescale 1ns / 1ps
// status_led_pattern_engine: top level of the RGB status pixel pattern engine.
// Depends on slpe_pkg, slpe_in_stage and slpe_core.
//
// Usage:
//   s_* channel carries events: op tick (one millisecond), set pattern or
//   start flash, with pattern, flash_color and flash_duration alongside.
//   m_* channel returns one result per event: the pixel colour after the
//   event and the flashing flag.
//   cfg_* channel writes the breath interval (index 0) and the blink
//   interval (index 1); write it only while no event is in flight.
// Path: the input register loads at the input transfer; the update logic then
//   fills the result register when the held event advances, which m_ready low
//   can hold back.
// Throughput: one event per cycle while m_ready is high; the whole update is
//   combinational logic between the input register and the result register.
// Stall: when m_ready is low the result register holds, the input register
//   fills and s_ready drops; nothing is lost or repeated.
// Reset (aresetn low, synchronous): pattern off, pixel dark, no flash,
//   intervals back to 20 ms and 500 ms, both channels empty.
module status_led_pattern_engine (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [slpe_pkg::OP_W-1:0]             s_op,
    input  logic [slpe_pkg::PATTERN_W-1:0]        s_pattern,
    input  logic [slpe_pkg::COLOR_W-1:0]          s_flash_color,
    input  logic [slpe_pkg::DURATION_W-1:0]       s_flash_duration,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [slpe_pkg::LEVEL_W-1:0]          m_red,
    output logic [slpe_pkg::LEVEL_W-1:0]          m_green,
    output logic [slpe_pkg::LEVEL_W-1:0]          m_blue,
    output logic                                  m_flashing,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [slpe_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [slpe_pkg::INTERVAL_W-1:0]       cfg_data
);

    slpe_pkg::item_t s_item;
    slpe_pkg::item_t item;
    logic            item_valid;
    logic            item_ready;

    assign s_item.op             = s_op;
    assign s_item.pattern        = s_pattern;
    assign s_item.flash_color    = s_flash_color;
    assign s_item.flash_duration = s_flash_duration;

    slpe_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item)
    );

    slpe_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_red      (m_red),
        .m_green    (m_green),
        .m_blue     (m_blue),
        .m_flashing (m_flashing)
    );

endmodule

### design/slpe_in_stage.sv
`timescale 1ns / 1ps
// slpe_in_stage: input register of the event channel.
// Depends on slpe_pkg (item_t).
module slpe_in_stage (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  slpe_pkg::item_t     s_item,
    output logic                item_valid,
    input  logic                item_ready,
    output slpe_pkg::item_t     item
);

    logic            valid_reg;
    slpe_pkg::item_t item_reg;

    // Refill in the same cycle the held item moves on.
    assign s_ready    = !valid_reg || item_ready;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

endmodule

### design/slpe_core.sv
`timescale 1ns / 1ps
// slpe_core: pattern state, configuration registers, event update and result register.
// Depends on slpe_pkg.
module slpe_core (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [slpe_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [slpe_pkg::INTERVAL_W-1:0]       cfg_data,
    input  logic                                  item_valid,
    output logic                                  item_ready,
    input  slpe_pkg::item_t                       item,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [slpe_pkg::LEVEL_W-1:0]          m_red,
    output logic [slpe_pkg::LEVEL_W-1:0]          m_green,
    output logic [slpe_pkg::LEVEL_W-1:0]          m_blue,
    output logic                                  m_flashing
);

    logic [slpe_pkg::INTERVAL_W-1:0] breath_interval_reg;
    logic [slpe_pkg::INTERVAL_W-1:0] blink_interval_reg;

    logic [slpe_pkg::PATTERN_W-1:0]  active_reg,  active_next;
    logic [slpe_pkg::PATTERN_W-1:0]  saved_reg,   saved_next;
    logic                            flash_on_reg, flash_on_next;
    logic [slpe_pkg::DURATION_W-1:0] remaining_reg, remaining_next;
    logic [slpe_pkg::INTERVAL_W-1:0] elapsed_reg, elapsed_next;
    logic [slpe_pkg::LEVEL_W-1:0]    level_reg,   level_next;
    logic                            rising_reg,  rising_next;
    logic [slpe_pkg::COLOR_W-1:0]    pixel_reg,   pixel_next;

    logic                            out_valid_reg;
    logic [slpe_pkg::COLOR_W-1:0]    out_pixel_reg;
    logic                            out_flashing_reg;

    logic                            advance;
    logic                            run;
    logic [slpe_pkg::PATTERN_W-1:0]  run_pat;
    logic [slpe_pkg::INTERVAL_W-1:0] elapsed_inc;
    logic [slpe_pkg::DURATION_W-1:0] remaining_dec;
    logic                            breath_due;
    logic                            blink_due;
    logic [slpe_pkg::LEVEL_W:0]      breath_sum;
    logic [slpe_pkg::LEVEL_W-1:0]    step_level;
    logic                            step_rising;

    assign cfg_ready  = 1'b1;
    assign item_ready = !out_valid_reg || m_ready;
    assign advance    = item_valid && item_ready;

    assign m_valid    = out_valid_reg;
    assign m_red      = out_pixel_reg[23:16];
    assign m_green    = out_pixel_reg[15:8];
    assign m_blue     = out_pixel_reg[7:0];
    assign m_flashing = out_flashing_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            breath_interval_reg <= slpe_pkg::BREATH_INTERVAL_RST;
            blink_interval_reg  <= slpe_pkg::BLINK_INTERVAL_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                slpe_pkg::CFG_BREATH_INTERVAL: breath_interval_reg <= cfg_data;
                slpe_pkg::CFG_BLINK_INTERVAL:  blink_interval_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    assign elapsed_inc   = (elapsed_reg == slpe_pkg::ELAPSED_MAX) ? elapsed_reg
                                                                  : elapsed_reg + 1'b1;
    assign remaining_dec = (remaining_reg == '0) ? remaining_reg : remaining_reg - 1'b1;
    assign breath_due    = elapsed_inc >= breath_interval_reg;
    assign blink_due     = elapsed_inc >= blink_interval_reg;
    assign breath_sum    = {1'b0, level_reg} + {1'b0, slpe_pkg::BREATH_STEP};

    // One breathing step: clamp at the top, bounce off the floor.
    always_comb begin
        step_level  = level_reg;
        step_rising = rising_reg;
        if (rising_reg) begin
            if (breath_sum >= {1'b0, slpe_pkg::BREATH_TOP}) begin
                step_level  = slpe_pkg::BREATH_TOP;
                step_rising = 1'b0;
            end else begin
                step_level = breath_sum[slpe_pkg::LEVEL_W-1:0];
            end
        end else if (level_reg <= slpe_pkg::BREATH_FLOOR + slpe_pkg::BREATH_STEP) begin
            step_level  = slpe_pkg::BREATH_FLOOR;
            step_rising = 1'b1;
        end else begin
            step_level = level_reg - slpe_pkg::BREATH_STEP;
        end
    end

    always_comb begin
        active_next    = active_reg;
        saved_next     = saved_reg;
        flash_on_next  = flash_on_reg;
        remaining_next = remaining_reg;
        elapsed_next   = elapsed_reg;
        level_next     = level_reg;
        rising_next    = rising_reg;
        pixel_next     = pixel_reg;
        run            = 1'b0;
        run_pat        = active_reg;

        case (item.op)
            slpe_pkg::OP_TICK: begin
                elapsed_next = elapsed_inc;
                if (flash_on_reg) begin
                    remaining_next = remaining_dec;
                    if (remaining_dec == '0) begin
                        flash_on_next = 1'b0;
                        active_next   = saved_reg;
                        run           = 1'b1;
                        run_pat       = saved_reg;
                    end
                end else begin
                    run = 1'b1;
                end
            end
            slpe_pkg::OP_SET: begin
                active_next = item.pattern;
                level_next  = '0;
                rising_next = 1'b1;
            end
            slpe_pkg::OP_FLASH: begin
                if (!flash_on_reg) begin
                    saved_next = active_reg;
                end
                flash_on_next  = 1'b1;
                remaining_next = item.flash_duration;
                pixel_next     = item.flash_color;
            end
            default: ;
        endcase

        if (run) begin
            case (run_pat)
                slpe_pkg::PAT_OFF:    pixel_next = slpe_pkg::COLOR_DARK;
                slpe_pkg::PAT_GREEN:  pixel_next = slpe_pkg::COLOR_GREEN;
                slpe_pkg::PAT_BLUE:   pixel_next = slpe_pkg::COLOR_BLUE;
                slpe_pkg::PAT_PURPLE: pixel_next = slpe_pkg::COLOR_PURPLE;
                slpe_pkg::PAT_BREATH_RED: begin
                    if (breath_due) begin
                        elapsed_next = '0;
                        level_next   = step_level;
                        rising_next  = step_rising;
                        pixel_next   = {step_level, 8'h00, 8'h00};
                    end
                end
                slpe_pkg::PAT_BREATH_YELLOW: begin
                    if (breath_due) begin
                        elapsed_next = '0;
                        level_next   = step_level;
                        rising_next  = step_rising;
                        pixel_next   = {step_level, step_level, 8'h00};
                    end
                end
                slpe_pkg::PAT_BLINK_WHITE: begin
                    if (blink_due) begin
                        elapsed_next = '0;
                        rising_next  = !rising_reg;
                        pixel_next   = rising_reg ? slpe_pkg::COLOR_DARK
                                                  : slpe_pkg::COLOR_WHITE;
                    end
                end
                default: ;  // unused code: pixel holds
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg    <= slpe_pkg::PAT_OFF;
            saved_reg     <= slpe_pkg::PAT_OFF;
            flash_on_reg  <= 1'b0;
            remaining_reg <= '0;
            elapsed_reg   <= '0;
            level_reg     <= '0;
            rising_reg    <= 1'b1;
            pixel_reg     <= slpe_pkg::COLOR_DARK;
        end else if (advance) begin
            active_reg    <= active_next;
            saved_reg     <= saved_next;
            flash_on_reg  <= flash_on_next;
            remaining_reg <= remaining_next;
            elapsed_reg   <= elapsed_next;
            level_reg     <= level_next;
            rising_reg    <= rising_next;
            pixel_reg     <= pixel_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (item_ready) begin
            out_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_pixel_reg    <= pixel_next;
            out_flashing_reg <= flash_on_next;
        end
    end

    a_flash_sets_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && item.op == slpe_pkg::OP_FLASH |=> m_valid && m_flashing)
        else $error("flash transfer did not raise flashing");

    a_flash_expires: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && item.op == slpe_pkg::OP_TICK && flash_on_reg && remaining_reg <= 16'd1
        |=> !flash_on_reg)
        else $error("flash did not end on its last tick");

    a_set_restarts_breath: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && item.op == slpe_pkg::OP_SET |=> level_reg == '0 && rising_reg)
        else $error("set pattern did not restart breathing");

    a_solid_green: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && item.op == slpe_pkg::OP_TICK && !flash_on_reg
        && active_reg == slpe_pkg::PAT_GREEN
        |=> m_red == 8'h00 && m_green == 8'hFF && m_blue == 8'h00)
        else $error("solid green tick gave wrong pixel");

endmodule
